@@ sv/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 byte hasher.
package sha_pkg;

   localparam int unsigned RoundCount = 64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      BLK_DATA,
      BLK_PAD_ONLY,
      BLK_PAD_LEN,
      BLK_LEN_ONLY
   } block_kind_type;

   localparam logic [7:0] PadByte = 8'h80;

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ sv/sha_queue.sv @@
// Two-entry queue of input beats between the front and the hashing engine.
module sha_queue
   import sha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   item_type   slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ sv/sha_engine.sv @@
// Back end: block buffer, message schedule, round loop and digest output.
module sha_engine
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_final_word,
   output logic        busy
);

   back_state_type state_ff, state_in;
   block_kind_type kind_ff, kind_in;

   // block buffer, four bytes per word, first byte in the high lane
   logic [31:0] buf_ff [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  rnd_ff;
   logic        close_ff, close_in;   // message closes after the current block
   logic [2:0]  out_idx_ff, out_idx_in;

   // sampled block word for the load step
   logic [31:0] blk_word [16];
   logic [63:0] total;

   assign total = len_ff + {55'd0, fill_ff, 3'd0};

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         for (int b = 0; b < 4; b++) begin
            logic [5:0] p;
            logic [7:0] d;
            p = 6'(4 * i + b);
            case (kind_ff)
               BLK_DATA:     d = buf_ff[i][31 - 8 * b -: 8];
               BLK_LEN_ONLY: d = 8'd0;
               default: begin
                  if (p < fill_ff)
                     d = buf_ff[i][31 - 8 * b -: 8];
                  else if (p == fill_ff)
                     d = PadByte;
                  else
                     d = 8'd0;
               end
            endcase
            blk_word[i][31 - 8 * b -: 8] = d;
         end
      end
      if (kind_ff inside {BLK_PAD_LEN, BLK_LEN_ONLY}) begin
         blk_word[14] = total[63:32];
         blk_word[15] = total[31:0];
      end
   end

   // round logic
   logic [31:0] t1, t2, s0, s1, wn;
   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = s1 + w_ff[9] + s0 + w_ff[0];
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + RoundK[rnd_ff] + w_ff[0];
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   logic take;
   assign take = (state_ff == ST_IDLE) && item_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && ((item.byte_present && fill_ff == 6'd63)
                         || item.end_of_message))
               state_in = ST_LOAD;
         end
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'(RoundCount - 1)) state_in = ST_ADD;
         ST_ADD: begin
            if (kind_ff inside {BLK_PAD_LEN, BLK_LEN_ONLY}) state_in = ST_EMIT;
            else if (close_ff) state_in = ST_LOAD;
            else state_in = ST_IDLE;
         end
         ST_EMIT:  if (!rsp_stall && out_idx_ff == 3'd7) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_pop        = take;
      busy            = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_EMIT);
      rsp_digest_word = h_ff[out_idx_ff];
      rsp_word_index  = out_idx_ff;
      rsp_final_word  = (out_idx_ff == 3'd7);
   end

   // kind and fill/length bookkeeping for the next block
   always_comb begin
      kind_in    = kind_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      close_in   = close_ff;
      out_idx_in = out_idx_ff;
      if (take) begin
         close_in = item.end_of_message;
         if (item.byte_present) begin
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               kind_in = BLK_DATA;
            end
         end
         if (item.end_of_message && !(item.byte_present && fill_ff == 6'd63)) begin
            // padding fits in this block when under 56 bytes remain used
            kind_in = (fill_in < 6'd56) ? BLK_PAD_LEN : BLK_PAD_ONLY;
         end
      end else if (state_ff == ST_ADD) begin
         if (kind_ff == BLK_DATA) begin
            len_in = len_ff + 64'd512;
            if (close_ff) kind_in = BLK_PAD_LEN;  // fresh block, pad at 0
         end else if (kind_ff == BLK_PAD_ONLY) begin
            kind_in = BLK_LEN_ONLY;
         end
      end else if (state_ff == ST_EMIT && !rsp_stall) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == 3'd7) begin
            fill_in  = 6'd0;
            len_in   = 64'd0;
            close_in = 1'b0;
            kind_in  = BLK_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         kind_ff    <= BLK_DATA;
         fill_ff    <= 6'd0;
         len_ff     <= 64'd0;
         close_ff   <= 1'b0;
         out_idx_ff <= 3'd0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
      end else begin
         state_ff   <= state_in;
         kind_ff    <= kind_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         close_ff   <= close_in;
         out_idx_ff <= out_idx_in;
         case (state_ff)
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            end
            ST_EMIT: begin
               if (!rsp_stall && out_idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take && item.byte_present)
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= item.data_byte;
      case (state_ff)
         ST_LOAD: begin
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            for (int i = 0; i < 16; i++) w_ff[i] <= blk_word[i];
            rnd_ff <= 6'd0;
         end
         ST_ROUND: begin
            v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
            w_ff[15] <= wn;
            rnd_ff <= rnd_ff + 6'd1;
         end
         default: ;
      endcase
   end

endmodule

@@ sv/sha256_byte_stream_hasher.sv @@
// An accepted beat is registered in the queue and reaches the engine in the cycle after
// it is accepted; the engine takes it only while idle. Each full block passes through the
// load, round and add states, in which the engine takes no beat, so the two-entry queue
// fills and stalls the input. A closing beat takes one or two padding blocks, then 8
// digest beats.
// Synchronous active-high reset loads the initial hash and clears counts and the queue.
module sha256_byte_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_final_word
);

   item_type in_item, head;
   logic     full, not_empty, pop, busy;

   assign in_item = '{data_byte: req_data_byte, byte_present: req_byte_present,
                      end_of_message: req_end_of_message};
   assign req_stall = full;

   sha_queue u_queue (
      .clock, .reset,
      .push(req_valid && !full), .push_item(in_item), .full,
      .pop, .not_empty, .head
   );

   sha_engine u_engine (
      .clock, .reset,
      .item_valid(not_empty), .item(head), .item_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index,
      .rsp_final_word, .busy
   );

`ifndef SYNTH
   a_final_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_word == (rsp_word_index == 3'd7)))
      else $error("final_word mismatch");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !pop)
      else $error("engine took a beat while busy");
   a_word_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_final_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");
`endif

endmodule

@@ test/sha256_byte_stream_hasher_test.sv @@
// Testbench for the SHA-256 byte-stream hasher: directed table, random messages, digest check.
module sha256_byte_stream_hasher_test
   import sha_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } digest_beat_type;

   typedef struct packed {
      logic        has_known;
      logic [31:0] h0;
   } known_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
      logic       has_known;
      logic [31:0] known_h0;
   } stim_row_type;

   localparam int WatchdogLimit = 20000;
   localparam int StallHoldCycles = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_final_word;

   sha256_byte_stream_hasher dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] hash_words [8];
   logic [7:0]  msg_block [64];
   int unsigned block_fill;
   logic [63:0] completed_bits;

   digest_beat_type pending_digest [$];
   known_type       known_queue [$];
   known_type       next_known = '0;
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   bit              stimulus_done = 1'b0;
   bit              hold_off = 1'b0;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_message_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (int r = 16; r < 64; r++)
         w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
              + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      for (int r = 0; r < 8; r++) v[r] = hash_words[r];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int r = 0; r < 8; r++) hash_words[r] += v[r];
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) hash_words[i] = InitH[i];
      block_fill = 0;
      completed_bits = '0;
   endfunction

   // Advance the predictor by one accepted beat and queue any digest it closes.
   function automatic void predict_digest(input logic [7:0] b, input logic present,
                                          input logic close);
      logic [63:0] total;
      int unsigned i;
      if (present) begin
         msg_block[block_fill] = b;
         block_fill++;
         if (block_fill == 64) begin
            compress_message_block();
            completed_bits += 64'd512;
            block_fill = 0;
         end
      end
      if (!close) return;
      total = completed_bits + 64'(block_fill) * 8;
      i = block_fill;
      msg_block[i] = PadByte;
      i++;
      if (i > 56) begin
         while (i < 64) begin
            msg_block[i] = '0;
            i++;
         end
         compress_message_block();
         i = 0;
      end
      while (i < 56) begin
         msg_block[i] = '0;
         i++;
      end
      for (int k = 0; k < 8; k++) msg_block[63-k] = total[8*k +: 8];
      compress_message_block();
      for (int k = 0; k < 8; k++)
         pending_digest.push_back('{hash_words[k], 3'(k), k == 7});
      known_queue.push_back(next_known);
      next_known = '0;
      restart_message();
   endfunction

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic present, input logic close);
      int gap;
      gap = short_or_long_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_byte_present <= present;
      req_end_of_message <= close;
      do @(posedge clock); while (req_stall);
      predict_digest(b, present, close);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_beat(8'($urandom), 1'b1, 1'b0);
      if ($urandom_range(0, 1)) send_beat(8'($urandom), 1'b1, 1'b1);
      else send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   // Directed table: known digests are typed in for the empty message and "abc".
   stim_row_type directed_rows [] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
      '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
      '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'haa, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h55, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442}
   };

   initial begin
      int len;
      restart_message();
      for (int i = 0; i < 64; i++) msg_block[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         next_known = '{directed_rows[i].has_known, directed_rows[i].known_h0};
         send_beat(directed_rows[i].data_byte, directed_rows[i].byte_present,
                   directed_rows[i].end_of_message);
      end
      // block-boundary closes: 54, 55, 62, 63, 64 bytes, then a closing beat with or without a byte
      send_message(54); send_message(55); send_message(62); send_message(63);
      send_message(64);
      // long stall window while bytes keep flowing
      hold_off = 1'b1;
      send_message(20); send_message(5); send_message(3);
      hold_off = 1'b0;
      len = 0;
      while (len < 90) begin
         case ($urandom_range(0, 9))
            0: begin
               send_beat(8'($urandom), 1'b0, 1'b0);
               len += 1;
            end
            1: begin
               int m;
               m = $urandom_range(65, 100);
               send_message(m);
               len += m + 1;
            end
            default: begin
               int n;
               n = $urandom_range(0, 12);
               send_message(n);
               len += n + 1;
            end
         endcase
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // result side: random stalls, one long hold-off
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (StallHoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
            wait (!hold_off);
         end
         gap = short_or_long_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      digest_beat_type want;
      digest_beat_type got;
      known_type       known;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_digest_word, rsp_word_index, rsp_final_word};
         if (pending_digest.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest beat: word %h index %0d final %b",
                        got.digest_word, got.word_index, got.final_word);
         end else begin
            want = pending_digest.pop_front();
            if (want.word_index == 3'd0 && known_queue.size() > 0) begin
               known = known_queue.pop_front();
               if (known.has_known && got.digest_word !== known.h0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("known digest mismatch: expected %h got %h",
                              known.h0, got.digest_word);
               end
            end
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                           want.digest_word, want.word_index, want.final_word,
                           got.digest_word, got.word_index, got.final_word);
            end
         end
      end
   end

   // watchdog on accepted beats on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (stimulus_done);
      while (pending_digest.size() != 0 && idle_cycles < WatchdogLimit) @(posedge clock);
      if (idle_cycles < WatchdogLimit) repeat (200) @(posedge clock);
      if (idle_cycles >= WatchdogLimit) begin
         $display("sha256_byte_stream_hasher_test: FAIL");
      end else if (mismatch_count == 0 && known_queue.size() == 0) begin
         $display("sha256_byte_stream_hasher_test: PASS");
      end else begin
         $display("sha256_byte_stream_hasher_test: FAIL");
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= WatchdogLimit);
      if (!stimulus_done) begin
         $display("sha256_byte_stream_hasher_test: FAIL");
         $finish;
      end
   end
endmodule
